// ===== src/rtwl_pkg.sv =====
// ----------------------------------------------------------------------------
// rtwl_pkg
// shared types and codes for the ranked tuple window list
// ----------------------------------------------------------------------------
package rtwl_pkg;

  typedef enum logic [2:0] {
    KIND_REWIND = 3'd0,
    KIND_NEXT   = 3'd1,
    KIND_READ   = 3'd2,
    KIND_TAKE   = 3'd3,
    KIND_REMOVE = 3'd4,
    KIND_CLEAR  = 3'd5,
    KIND_RANK   = 3'd6,
    KIND_PUT    = 3'd7
  } kind_t;

  localparam logic [1:0] POL_APPEND  = 2'd0;
  localparam logic [1:0] POL_PREPEND = 2'd1;
  localparam logic [1:0] POL_RANKED  = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOENTRY = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_EVICTED = 2'd3;

  localparam logic ADDR_POLICY    = 1'b0;
  localparam logic ADDR_MAX_SLOTS = 1'b1;

  localparam logic [31:0] RANK_FLOOR = 32'h0000_0001;

  // one command beat as it sits in the queue
  typedef struct packed {
    kind_t        kind;
    logic [31:0]  payload;
    logic [63:0]  stamp;
    logic [31:0]  rank_value;
    logic         forced;
  } cmd_t;

endpackage

// ===== src/rtwl_front.sv =====
// ----------------------------------------------------------------------------
// rtwl_front
// accepts command beats and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module rtwl_front
  import rtwl_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic avail,
  output cmd_t head
);

  cmd_t       q [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign avail = (count != 2'd0);
  assign head  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== src/rtwl_back.sv =====
// ----------------------------------------------------------------------------
// rtwl_back
// list engine: runs one command at a time through a sequence of states on the link stores
// ----------------------------------------------------------------------------
module rtwl_back
  import rtwl_pkg::*;
#(
  parameter int SLOTS = 64,
  parameter int IW    = $clog2(SLOTS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [1:0]    policy,
  input  logic [6:0]    max_slots,
  input  logic          avail,
  input  cmd_t          cmd,
  output logic          pop,
  output logic          done,
  output logic [1:0]    status,
  output logic [31:0]   out_payload,
  output logic [63:0]   out_stamp,
  output logic          at_end,
  output logic          has_free,
  output logic          idle
);

  localparam logic [IW-1:0] SENT = IW'(SLOTS);
  localparam int SW = $clog2(SLOTS);
  localparam logic [IW:0] CNT_ONE = (IW+1)'(1);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_FETCH  = 8'b00000010,
    S_EXEC   = 8'b00000100,
    S_TAIL   = 8'b00001000,
    S_EVICT  = 8'b00010000,
    S_LINK   = 8'b00100000,
    S_LINK2  = 8'b01000000,
    S_RESP   = 8'b10000000
  } state_t;

  state_t state;

  // link stores, sentinel at index SLOTS
  logic [IW-1:0] next_link [SLOTS+1];
  logic [IW-1:0] prev_link [SLOTS+1];
  logic [31:0]   entry_handle [SLOTS];
  logic [63:0]   entry_time   [SLOTS];
  logic [31:0]   entry_rank   [SLOTS];
  logic [SLOTS-1:0] used_mask;

  logic [IW-1:0] cursor_pos;
  logic [IW-1:0] rank_point;
  logic [31:0]   insert_rank;
  logic [IW:0]   entry_count;

  cmd_t          cur;
  logic [IW-1:0] node;        // node being worked on
  logic [IW-1:0] nx, pv;      // its neighbors, registered
  logic [31:0]   rd_handle, rd_rank;
  logic [63:0]   rd_time;
  logic          evicted;
  logic [SW-1:0] free_slot;
  logic          free_ok;

  // limit in force is min(max_slots, SLOTS)
  logic [IW:0] lim;
  always_comb begin
    if (int'(max_slots) >= SLOTS)
      lim = (IW+1)'(SLOTS);
    else
      lim = (IW+1)'(max_slots);
  end
  logic room;
  assign room = entry_count < lim;

  // lowest free slot
  always_comb begin
    free_slot = '0;
    free_ok   = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_mask[i]) begin
        free_slot = SW'(i);
        free_ok   = 1'b1;
      end
    end
  end

  assign idle = (state == S_IDLE);
  assign pop  = (state == S_IDLE) && avail;

  // node under work read from the stores
  logic [IW-1:0] node_next, node_prev;
  assign node_next = next_link[node];
  assign node_prev = prev_link[node];

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      used_mask   <= '0;
      cursor_pos  <= SENT;
      rank_point  <= SENT;
      insert_rank <= '0;
      entry_count <= '0;
      next_link[SLOTS] <= SENT;
      prev_link[SLOTS] <= SENT;
    end else begin
      done <= (state == S_RESP);
      unique case (state)
        S_IDLE: begin
          if (avail) begin
            cur         <= cmd;
            status      <= ST_DONE;
            out_payload <= '0;
            out_stamp   <= '0;
            evicted     <= 1'b0;
            // rewind and put look at the sentinel: head and tail
            if (cmd.kind == KIND_PUT || cmd.kind == KIND_REWIND) begin
              node <= SENT;
            end else begin
              node <= cursor_pos;
            end
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          nx <= node_next;
          pv <= node_prev;
          if (node != SENT) begin
            rd_handle <= entry_handle[node[SW-1:0]];
            rd_time   <= entry_time[node[SW-1:0]];
            rd_rank   <= entry_rank[node[SW-1:0]];
          end
          state <= S_EXEC;
        end
        S_EXEC: begin
          unique case (cur.kind) inside
            KIND_REWIND: begin
              cursor_pos <= nx;
              rank_point <= nx;
              state      <= S_RESP;
            end
            KIND_NEXT: begin
              if (node != SENT) begin
                if (policy == POL_RANKED && node == rank_point &&
                    $signed(rd_rank) <= $signed(insert_rank))
                  rank_point <= nx;
                cursor_pos <= nx;
              end
              state <= S_RESP;
            end
            KIND_READ, KIND_TAKE, KIND_REMOVE: begin
              if (node == SENT) begin
                status <= ST_NOENTRY;
              end else begin
                if (cur.kind != KIND_REMOVE) begin
                  out_payload <= rd_handle;
                  out_stamp   <= rd_time;
                end
                if (cur.kind != KIND_READ) begin
                  next_link[pv] <= nx;
                  prev_link[nx] <= pv;
                  used_mask[node[SW-1:0]] <= 1'b0;
                  if (entry_count != '0) entry_count <= entry_count - CNT_ONE;
                  cursor_pos <= nx;
                  if (rank_point == node) rank_point <= nx;
                end
              end
              state <= S_RESP;
            end
            KIND_CLEAR: begin
              used_mask   <= '0;
              next_link[SLOTS] <= SENT;
              prev_link[SLOTS] <= SENT;
              cursor_pos  <= SENT;
              rank_point  <= SENT;
              entry_count <= '0;
              state       <= S_RESP;
            end
            KIND_RANK: begin
              insert_rank <= cur.rank_value;
              state       <= S_RESP;
            end
            KIND_PUT: begin
              // nx is the head and pv the tail here
              if (policy == POL_RANKED) begin
                if (!room) begin
                  if (!cur.forced || pv == SENT) begin
                    status <= ST_FULL;
                    state  <= S_RESP;
                  end else begin
                    node  <= pv;
                    state <= S_TAIL;
                  end
                end else begin
                  node  <= rank_point;
                  state <= S_LINK;
                end
              end else if (!room) begin
                status <= cur.forced ? ST_DONE : ST_FULL;
                state  <= S_RESP;
              end else begin
                node  <= (policy == POL_PREPEND) ? nx : SENT;
                state <= S_LINK;
              end
            end
            default: state <= S_RESP;
          endcase
        end
        S_TAIL: begin
          // neighbors of the tail
          nx    <= node_next;
          pv    <= node_prev;
          state <= S_EVICT;
        end
        S_EVICT: begin
          next_link[pv] <= nx;
          prev_link[nx] <= pv;
          used_mask[node[SW-1:0]] <= 1'b0;
          if (entry_count != '0) entry_count <= entry_count - CNT_ONE;
          if (cursor_pos == node) cursor_pos <= nx;
          if (rank_point == node) rank_point <= nx;
          evicted <= 1'b1;
          state   <= S_LINK;
          node    <= (rank_point == node) ? nx : rank_point;
        end
        S_LINK: begin
          if (!room || !free_ok) begin
            if (evicted || !room) status <= ST_FULL;
            state <= S_RESP;
          end else begin
            pv    <= node_prev;
            state <= S_LINK2;
          end
        end
        S_LINK2: begin
          entry_handle[free_slot] <= cur.payload;
          entry_time[free_slot]   <= cur.stamp;
          entry_rank[free_slot]   <= (policy == POL_RANKED) ? insert_rank : RANK_FLOOR;
          next_link[pv]           <= IW'(free_slot);
          prev_link[IW'(free_slot)] <= pv;
          next_link[IW'(free_slot)] <= node;
          prev_link[node]         <= IW'(free_slot);
          used_mask[free_slot]    <= 1'b1;
          entry_count             <= entry_count + CNT_ONE;
          status                  <= evicted ? ST_EVICTED : ST_DONE;
          state                   <= S_RESP;
        end
        S_RESP: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign at_end   = (cursor_pos == SENT);
  assign has_free = room;

endmodule

// ===== src/ranked_tuple_window_list.sv =====
// ----------------------------------------------------------------------------
// ranked_tuple_window_list
// bounded window of entries kept as a rank-ordered doubly linked list
// ----------------------------------------------------------------------------
// Commands enter on start while busy is low and go into a two-beat queue; the
// list engine takes them one at a time and steps each through fetch of the
// node's links, update, optional tail read and eviction, link of a put and
// respond, as the dependent reads and writes of the link store require. Each
// command yields one result beat marked by done, one cycle wide; the receiver
// cannot stall it. busy is high while the queue is full. The user must write
// configuration over the APB port while no command is pending; not enforced.
module ranked_tuple_window_list
  import rtwl_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind,
  input  logic [31:0] payload,
  input  logic [63:0] stamp,
  input  logic [31:0] rank_value,
  input  logic        forced,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] out_payload,
  output logic [63:0] out_stamp,
  output logic        at_end,
  output logic        has_free,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0] policy;
  logic [6:0] max_slots;

  // config registers at byte addresses 0 and 4
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      policy    <= POL_APPEND;
      max_slots <= 7'd64;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
      if (paddr[2] == ADDR_POLICY)    policy    <= pwdata[1:0];
      if (paddr[2] == ADDR_MAX_SLOTS) max_slots <= pwdata[6:0];
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'd0) begin
      if (paddr[2] == ADDR_POLICY) prdata = {30'd0, policy};
      else                         prdata = {25'd0, max_slots};
    end
  end

  cmd_t in_cmd, head;
  logic q_full, q_avail, q_pop, eng_idle;

  assign in_cmd = '{kind: kind_t'(kind), payload: payload, stamp: stamp,
                    rank_value: rank_value, forced: forced};
  assign busy = q_full;

  rtwl_front u_front (
    .clk(clk), .rst(rst), .push(start && !busy), .push_cmd(in_cmd),
    .full(q_full), .pop(q_pop), .avail(q_avail), .head(head)
  );

  rtwl_back #(.SLOTS(SLOTS)) u_back (
    .clk(clk), .rst(rst), .policy(policy), .max_slots(max_slots),
    .avail(q_avail), .cmd(head), .pop(q_pop), .done(done),
    .status(status), .out_payload(out_payload), .out_stamp(out_stamp),
    .at_end(at_end), .has_free(has_free), .idle(eng_idle)
  );

  // a result beat comes only once the engine is back in idle
  assert property (@(posedge clk) disable iff (rst) done |-> eng_idle)
    else $error("done outside response");
  // a read on the sentinel returns no data
  assert property (@(posedge clk) disable iff (rst)
    done && status == ST_NOENTRY |-> out_payload == 32'd0 && out_stamp == 64'd0)
    else $error("data on empty cursor");
  // no pop from an empty queue
  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_avail)
    else $error("queue underflow");

endmodule

// ===== verif/tb_ranked_tuple_window_list.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ranked_tuple_window_list
// self-checking bench for the ranked tuple window list
// ----------------------------------------------------------------------------
// A queue of command beats feeds a clocked driver. An in-bench list model
// predicts the result of every accepted beat. A clocked monitor compares each
// done beat field by field against the oldest prediction. The run moves
// through phases with different policy and window limits. Between phases it
// drains all results and then rewrites the registers over APB.
module tb_ranked_tuple_window_list;
  import rtwl_pkg::*;

  localparam int NSLOT    = 64;
  localparam int SENTINEL = NSLOT;
  localparam int WD_LIMIT = 4000;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] payload;
    logic [63:0] stamp;
    logic        at_end;
    logic        has_free;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  kind;
  logic [31:0] payload;
  logic [63:0] stamp;
  logic [31:0] rank_value;
  logic        forced;
  logic        done;
  logic [1:0]  status;
  logic [31:0] out_payload;
  logic [63:0] out_stamp;
  logic        at_end;
  logic        has_free;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  always #1 clk = ~clk;

  ranked_tuple_window_list i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .kind(kind), .payload(payload), .stamp(stamp), .rank_value(rank_value),
    .forced(forced), .done(done), .status(status), .out_payload(out_payload),
    .out_stamp(out_stamp), .at_end(at_end), .has_free(has_free),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // command beats waiting to be driven, and predicted results in order
  cmd_t     cmd_queue[$];
  outcome_t outcome_queue[$];
  int       errors = 0;
  int       idle_pct = 0;
  bit       beat_taken = 1'b0;
  int       quiet_cycles = 0;

  // ---------------------------------------------------------------- list model
  logic [31:0] m_handle[NSLOT];
  logic [63:0] m_time[NSLOT];
  logic [31:0] m_rank[NSLOT];
  logic [6:0]  m_next[NSLOT+1];
  logic [6:0]  m_prev[NSLOT+1];
  bit          m_used[NSLOT];
  logic [6:0]  m_cursor;
  logic [6:0]  m_rank_pt;
  logic [31:0] m_ins_rank;
  int          m_count;
  logic [1:0]  m_policy;
  logic [6:0]  m_max;

  function automatic bit window_has_room();
    int lim;
    lim = (m_max < NSLOT) ? int'(m_max) : NSLOT;
    return m_count < lim;
  endfunction

  function automatic void model_empty();
    foreach (m_used[i]) m_used[i] = 1'b0;
    m_next[SENTINEL] = 7'(SENTINEL);
    m_prev[SENTINEL] = 7'(SENTINEL);
    m_cursor  = 7'(SENTINEL);
    m_rank_pt = 7'(SENTINEL);
    m_count   = 0;
  endfunction

  function automatic void model_unlink(logic [6:0] s);
    logic [6:0] n;
    logic [6:0] p;
    if (s >= SENTINEL) return;
    n = m_next[s];
    p = m_prev[s];
    m_next[p] = n;
    m_prev[n] = p;
    m_used[s] = 1'b0;
    if (m_count > 0) m_count--;
    if (m_cursor == s) m_cursor = n;
    if (m_rank_pt == s) m_rank_pt = n;
  endfunction

  // lowest free slot goes in before node at
  function automatic void model_link(logic [6:0] at, logic [31:0] pay, logic [63:0] st,
                                     logic [31:0] rk);
    int f;
    logic [6:0] p;
    f = 0;
    while (f < NSLOT && m_used[f]) f++;
    if (f >= NSLOT) return;
    m_handle[f] = pay;
    m_time[f]   = st;
    m_rank[f]   = rk;
    p = m_prev[at];
    m_next[p] = 7'(f);
    m_prev[f] = p;
    m_next[f] = at;
    m_prev[at] = 7'(f);
    m_used[f] = 1'b1;
    m_count++;
  endfunction

  function automatic outcome_t predict_outcome(cmd_t c);
    outcome_t   o;
    logic [6:0] cur;
    bit         evicted;
    o = '0;
    o.status = ST_DONE;
    case (c.kind)
      KIND_REWIND: begin
        m_cursor  = m_next[SENTINEL];
        m_rank_pt = m_next[SENTINEL];
      end
      KIND_NEXT: begin
        cur = m_cursor;
        if (cur != SENTINEL) begin
          if (m_policy == POL_RANKED && cur == m_rank_pt &&
              $signed(m_rank[cur]) <= $signed(m_ins_rank))
            m_rank_pt = m_next[cur];
          m_cursor = m_next[cur];
        end
      end
      KIND_READ, KIND_TAKE, KIND_REMOVE: begin
        cur = m_cursor;
        if (cur == SENTINEL) begin
          o.status = ST_NOENTRY;
        end else begin
          if (c.kind != KIND_REMOVE) begin
            o.payload = m_handle[cur];
            o.stamp   = m_time[cur];
          end
          if (c.kind != KIND_READ) model_unlink(cur);
        end
      end
      KIND_CLEAR: model_empty();
      KIND_RANK:  m_ins_rank = c.rank_value;
      default: begin
        if (m_policy == POL_RANKED) begin
          evicted = 1'b0;
          if (!window_has_room()) begin
            if (!c.forced || m_prev[SENTINEL] == SENTINEL) begin
              o.status = ST_FULL;
            end else begin
              model_unlink(m_prev[SENTINEL]);
              evicted = 1'b1;
            end
          end
          if (o.status != ST_FULL) begin
            if (!window_has_room()) begin
              o.status = ST_FULL;
            end else begin
              model_link(m_rank_pt, c.payload, c.stamp, m_ins_rank);
              o.status = evicted ? ST_EVICTED : ST_DONE;
            end
          end
        end else if (!window_has_room()) begin
          o.status = c.forced ? ST_DONE : ST_FULL;
        end else begin
          model_link(m_policy == POL_PREPEND ? m_next[SENTINEL] : 7'(SENTINEL),
                     c.payload, c.stamp, RANK_FLOOR);
        end
      end
    endcase
    o.at_end   = (m_cursor == SENTINEL);
    o.has_free = window_has_room();
    return o;
  endfunction

  // ---------------------------------------------------------------- driver
  // inputs change on the falling edge; a beat stays up until it is taken
  always @(negedge clk) begin
    if (!rst && (!start || beat_taken)) begin
      beat_taken = 1'b0;
      if (cmd_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
        start      <= 1'b1;
        kind       <= cmd_queue[0].kind;
        payload    <= cmd_queue[0].payload;
        stamp      <= cmd_queue[0].stamp;
        rank_value <= cmd_queue[0].rank_value;
        forced     <= cmd_queue[0].forced;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    outcome_t want;
    cmd_t     c;
    if (!rst) begin
      quiet_cycles++;
      // check the result beat first, then predict any newly taken command
      if (done) begin
        quiet_cycles = 0;
        if (outcome_queue.size() == 0) begin
          $display("%0t: result beat with nothing expected: status %0d payload %h",
                   $realtime, status, out_payload);
          errors++;
        end else begin
          want = outcome_queue.pop_front();
          if (status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime, want.status, status);
            errors++;
          end
          if (out_payload !== want.payload) begin
            $display("%0t: out_payload expected %h actual %h", $realtime, want.payload,
                     out_payload);
            errors++;
          end
          if (out_stamp !== want.stamp) begin
            $display("%0t: out_stamp expected %h actual %h", $realtime, want.stamp,
                     out_stamp);
            errors++;
          end
          if (at_end !== want.at_end) begin
            $display("%0t: at_end expected %0d actual %0d", $realtime, want.at_end, at_end);
            errors++;
          end
          if (has_free !== want.has_free) begin
            $display("%0t: has_free expected %0d actual %0d", $realtime, want.has_free,
                     has_free);
            errors++;
          end
        end
      end
      if (start && !busy && !beat_taken) begin
        quiet_cycles = 0;
        c = cmd_queue.pop_front();
        outcome_queue.push_back(predict_outcome(c));
        beat_taken = 1'b1;
      end
      if (quiet_cycles >= WD_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", WD_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_window(logic [1:0] pol, logic [6:0] maxs);
    reg_write({ADDR_POLICY, 2'b00}, {30'd0, pol});
    reg_write({ADDR_MAX_SLOTS, 2'b00}, {25'd0, maxs});
    m_policy = pol;
    m_max    = maxs;
  endtask

  function automatic void queue_cmd(kind_t k, logic [31:0] pay, logic [63:0] st,
                                    logic [31:0] rk, logic frc);
    cmd_t c;
    c.kind = k; c.payload = pay; c.stamp = st; c.rank_value = rk; c.forced = frc;
    cmd_queue.push_back(c);
  endfunction

  // random beat, weighted toward puts and walking; ranks often near each other
  function automatic void queue_random();
    int          r;
    kind_t       k;
    logic [31:0] rk;
    r = $urandom_range(99);
    if (r < 34)      k = KIND_PUT;
    else if (r < 54) k = KIND_NEXT;
    else if (r < 62) k = KIND_REWIND;
    else if (r < 72) k = KIND_READ;
    else if (r < 80) k = KIND_TAKE;
    else if (r < 86) k = KIND_REMOVE;
    else if (r < 97) k = KIND_RANK;
    else             k = KIND_CLEAR;
    rk = ($urandom_range(3) == 0) ? $urandom() : 32'($signed($urandom_range(8)) - 4);
    queue_cmd(k, $urandom(), {$urandom(), $urandom()}, rk, 1'($urandom_range(1)));
  endfunction

  // wait for every beat to be taken and every result to arrive
  task automatic drain();
    while (cmd_queue.size() > 0 || outcome_queue.size() > 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  initial begin
    logic [1:0] pol_list[9] = '{POL_APPEND, POL_PREPEND, POL_RANKED, POL_RANKED,
                                POL_APPEND, POL_RANKED, POL_PREPEND, POL_RANKED,
                                POL_APPEND};
    logic [6:0] max_list[9] = '{7'd64, 7'd5, 7'd8, 7'd1, 7'd1, 7'd64, 7'd64, 7'd3, 7'd7};
    rst = 1'b1; start = 1'b0; kind = KIND_REWIND; payload = '0; stamp = '0;
    rank_value = '0; forced = 1'b0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    paddr = '0; pwdata = '0;
    foreach (m_handle[i]) begin
      m_handle[i] = '0; m_time[i] = '0; m_rank[i] = '0;
    end
    foreach (m_next[i]) begin
      m_next[i] = '0; m_prev[i] = '0;
    end
    model_empty();
    m_ins_rank = '0;
    m_policy = POL_APPEND;
    m_max = 7'd64;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: empty list corners, field extremes, every operation
    set_window(POL_APPEND, 7'd64);
    idle_pct = 36;
    queue_cmd(KIND_READ,   '0, '0, '0, 1'b0);
    queue_cmd(KIND_TAKE,   '0, '0, '0, 1'b0);
    queue_cmd(KIND_REMOVE, '0, '0, '0, 1'b0);
    queue_cmd(KIND_NEXT,   '0, '0, '0, 1'b0);
    queue_cmd(KIND_PUT, 32'hFFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, '0, 1'b0);
    queue_cmd(KIND_PUT, 32'h0, 64'h8000_0000_0000_0000, '0, 1'b1);
    queue_cmd(KIND_PUT, 32'h5A5A_A5A5, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0);
    queue_cmd(KIND_REWIND, '0, '0, '0, 1'b0);
    queue_cmd(KIND_READ,   '0, '0, '0, 1'b0);
    queue_cmd(KIND_NEXT,   '0, '0, '0, 1'b0);
    queue_cmd(KIND_TAKE,   '0, '0, '0, 1'b0);
    queue_cmd(KIND_READ,   '0, '0, '0, 1'b0);
    queue_cmd(KIND_REMOVE, '0, '0, '0, 1'b0);
    queue_cmd(KIND_NEXT,   '0, '0, '0, 1'b0);
    queue_cmd(KIND_RANK, '0, '0, 32'h8000_0000, 1'b0);
    queue_cmd(KIND_RANK, '0, '0, 32'h7FFF_FFFF, 1'b0);
    queue_cmd(KIND_CLEAR,  '0, '0, '0, 1'b0);
    queue_cmd(KIND_READ,   '0, '0, '0, 1'b0);
    drain();

    // full window: non-ranked drop and flag, ranked eviction and refusal
    set_window(POL_APPEND, 7'd1);
    queue_cmd(KIND_PUT, 32'h1, 64'h1, '0, 1'b0);
    queue_cmd(KIND_PUT, 32'h2, 64'h2, '0, 1'b0);
    queue_cmd(KIND_PUT, 32'h3, 64'h3, '0, 1'b1);
    drain();
    set_window(POL_RANKED, 7'd1);
    queue_cmd(KIND_PUT, 32'h4, 64'h4, '0, 1'b1);
    queue_cmd(KIND_PUT, 32'h5, 64'h5, '0, 1'b0);
    queue_cmd(KIND_CLEAR, '0, '0, '0, 1'b0);
    drain();

    // random phases; each boundary waits out every result before the next write
    for (int ph = 0; ph < 9; ph++) begin
      set_window(pol_list[ph], max_list[ph]);
      idle_pct = (ph < 3) ? 36 : (ph < 6) ? 50 : 0;
      for (int n = 0; n < 80; n++) queue_random();
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
